>>> rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types, constants and commands of the fuzzy rule controller.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam int MAX_RULES = 8;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam logic [15:0] Q15_ONE = 16'h8000;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_LIST   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPEND,
    ST_RULE,
    ST_MDIV,
    ST_ACC,
    ST_EMIT,
    ST_FDIV,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    OUT_APPEND,
    OUT_EVAL,
    OUT_LIST
  } out_kind_t;

  typedef struct packed {
    logic       load;       // capture input item
    logic       write_rule; // append rule to table
    logic       clr_acc;
    logic       rule_start; // compute numerator/denominator for current rule
    logic       mdiv_step;
    logic       acc;        // accumulate membership
    logic       fdiv_start;
    logic       fdiv_step;
    logic       next_rule;
    logic       set_out;    // load output register
    out_kind_t  out_kind;
  } ctrl_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       full;
    logic       empty;
    logic       last_rule;
    logic       div_done;
    logic       total_zero;
  } stat_t;

endpackage

>>> rtl/frc_if.sv
// ----------------------------------------------------------------------------
// frc_in_if / frc_out_if
// Valid/ready channels of the fuzzy rule controller.
// ----------------------------------------------------------------------------
interface frc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] sample;
  logic signed [15:0] rule_left;
  logic signed [15:0] rule_peak;
  logic signed [15:0] rule_right;
  logic signed [15:0] rule_output;
  modport source (output valid, cmd, sample, rule_left, rule_peak, rule_right,
                  rule_output, input ready);
  modport sink (input valid, cmd, sample, rule_left, rule_peak, rule_right,
                rule_output, output ready);
endinterface

interface frc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic [15:0]        strength;
  logic [2:0]         rule_index;
  logic               status;
  logic               last;
  modport source (output valid, drive, strength, rule_index, status, last,
                  input ready);
  modport sink (input valid, drive, strength, rule_index, status, last,
                output ready);
endinterface

>>> rtl/frc_ctrl.sv
// ----------------------------------------------------------------------------
// frc_ctrl
// Sequencer: walks the rules, steps the shared divider, emits beats.
// ----------------------------------------------------------------------------
module frc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  frc_pkg::stat_t  stat,
  output frc_pkg::ctrl_t  ctrl
);

  frc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      frc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_next = frc_pkg::ST_APPEND;
        end
      end
      frc_pkg::ST_APPEND: begin
        // dispatch on captured command
        ctrl.clr_acc = 1'b1;
        case (stat.cmd)
          frc_pkg::CMD_APPEND: begin
            ctrl.write_rule = 1'b1;
            ctrl.set_out    = 1'b1;
            ctrl.out_kind   = frc_pkg::OUT_APPEND;
            state_next      = frc_pkg::ST_OUT;
          end
          frc_pkg::CMD_EVAL: begin
            state_next = stat.empty ? frc_pkg::ST_DONE : frc_pkg::ST_RULE;
          end
          frc_pkg::CMD_LIST: begin
            state_next = stat.empty ? frc_pkg::ST_IDLE : frc_pkg::ST_RULE;
          end
          default: begin
            state_next = frc_pkg::ST_IDLE;
          end
        endcase
      end
      frc_pkg::ST_RULE: begin
        ctrl.rule_start = 1'b1;
        state_next = frc_pkg::ST_MDIV;
      end
      frc_pkg::ST_MDIV: begin
        ctrl.mdiv_step = 1'b1;
        if (stat.div_done) begin
          state_next = frc_pkg::ST_ACC;
        end
      end
      frc_pkg::ST_ACC: begin
        ctrl.acc = 1'b1;
        if (stat.cmd == frc_pkg::CMD_LIST) begin
          ctrl.set_out  = 1'b1;
          ctrl.out_kind = frc_pkg::OUT_LIST;
          state_next    = frc_pkg::ST_EMIT;
        end else if (stat.last_rule) begin
          state_next = frc_pkg::ST_DONE;
        end else begin
          ctrl.next_rule = 1'b1;
          state_next     = frc_pkg::ST_RULE;
        end
      end
      frc_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.last_rule) begin
            state_next = frc_pkg::ST_IDLE;
          end else begin
            ctrl.next_rule = 1'b1;
            state_next     = frc_pkg::ST_RULE;
          end
        end
      end
      frc_pkg::ST_DONE: begin
        if (stat.total_zero) begin
          ctrl.set_out  = 1'b1;
          ctrl.out_kind = frc_pkg::OUT_EVAL;
          state_next    = frc_pkg::ST_OUT;
        end else begin
          ctrl.fdiv_start = 1'b1;
          state_next      = frc_pkg::ST_FDIV;
        end
      end
      frc_pkg::ST_FDIV: begin
        ctrl.fdiv_step = 1'b1;
        if (stat.div_done) begin
          ctrl.set_out  = 1'b1;
          ctrl.out_kind = frc_pkg::OUT_EVAL;
          state_next    = frc_pkg::ST_OUT;
        end
      end
      frc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = frc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = frc_pkg::ST_IDLE;
      end
    endcase
  end

  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    (state == frc_pkg::ST_IDLE) |-> !out_valid)
    else $error("result offered while idle");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result waits");
  a_load_seq: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |=> (state == frc_pkg::ST_APPEND))
    else $error("capture not followed by dispatch");

endmodule

>>> rtl/frc_datapath.sv
// ----------------------------------------------------------------------------
// frc_datapath
// Rule table, membership and final dividers (shared restoring divider),
// accumulators, nearest-peak fallback and output register.
// ----------------------------------------------------------------------------
module frc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  frc_pkg::ctrl_t     ctrl,
  output frc_pkg::stat_t     stat,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_sample,
  input  logic signed [15:0] in_left,
  input  logic signed [15:0] in_peak,
  input  logic signed [15:0] in_right,
  input  logic signed [15:0] in_output,
  output logic signed [15:0] drive,
  output logic [15:0]        strength,
  output logic [2:0]         rule_index,
  output logic               status,
  output logic               last
);

  localparam int DIV_W = 50;  // dividend/quotient width of the divider
  localparam int DEN_W = 16 + frc_pkg::CNT_W;  // total of MAX_RULES Q1.15 weights
  localparam int STEP_W = $clog2(DIV_W + 1);

  logic signed [15:0] left_mem [frc_pkg::MAX_RULES];
  logic signed [15:0] peak_mem [frc_pkg::MAX_RULES];
  logic signed [15:0] right_mem [frc_pkg::MAX_RULES];
  logic signed [15:0] out_mem [frc_pkg::MAX_RULES];

  logic [frc_pkg::CNT_W-1:0] rule_count;
  logic [frc_pkg::IDX_W-1:0] idx;
  logic [1:0]                cmd;
  logic signed [15:0]        s;
  logic signed [15:0]        new_left, new_peak, new_right, new_out;

  logic signed [16:0] s17, l17, p17, r17;
  logic               zero_m, one_m;
  logic [16:0]        num_m, den_m;

  logic [DIV_W-1:0]   quo;
  logic [DIV_W:0]     rem;
  logic [DIV_W-1:0]   dvd;
  logic [DIV_W-1:0]   dvs;
  logic [STEP_W-1:0]  steps;
  logic               neg_q;
  logic [DIV_W:0]     rem_try;

  logic [15:0]        mem_val;
  logic signed [40:0] weighted;
  logic [DEN_W-1:0]   total;
  logic               found;
  logic [16:0]        best;
  logic signed [15:0] near_out;
  logic signed [17:0] diff;
  logic [16:0]        adiff;
  logic signed [32:0] prod;

  // rule fields are held from the accepted beat; the channel may move on
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd       <= in_cmd;
      s         <= in_sample;
      new_left  <= in_left;
      new_peak  <= in_peak;
      new_right <= in_right;
      new_out   <= in_output;
    end
    if (ctrl.write_rule && !stat.full) begin
      left_mem[rule_count[frc_pkg::IDX_W-1:0]]  <= new_left;
      peak_mem[rule_count[frc_pkg::IDX_W-1:0]]  <= new_peak;
      right_mem[rule_count[frc_pkg::IDX_W-1:0]] <= new_right;
      out_mem[rule_count[frc_pkg::IDX_W-1:0]]   <= new_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
    end else if (ctrl.write_rule && !stat.full) begin
      rule_count <= rule_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr_acc) begin
      idx <= '0;
    end else if (ctrl.next_rule) begin
      idx <= idx + 1'b1;
    end
  end

  assign s17 = 17'(s);
  assign l17 = 17'(left_mem[idx]);
  assign p17 = 17'(peak_mem[idx]);
  assign r17 = 17'(right_mem[idx]);
  assign zero_m = (s17 <= l17) || (s17 >= r17);
  assign one_m  = (s17 == p17);
  assign num_m  = (s17 < p17) ? 17'(s17 - l17) : 17'(r17 - s17);
  assign den_m  = (s17 < p17) ? 17'(p17 - l17) : 17'(r17 - p17);

  // shared restoring divider, one quotient bit a cycle
  assign rem_try = {rem[DIV_W-1:0], dvd[DIV_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (ctrl.rule_start) begin
      dvd   <= DIV_W'({num_m, 15'd0});
      dvs   <= DIV_W'(den_m);
      rem   <= '0;
      quo   <= '0;
      steps <= STEP_W'(DIV_W);
      neg_q <= 1'b0;
    end else if (ctrl.fdiv_start) begin
      dvd   <= weighted[40] ? DIV_W'(-weighted) : DIV_W'(weighted);
      dvs   <= DIV_W'(total);
      rem   <= '0;
      quo   <= '0;
      steps <= STEP_W'(DIV_W);
      neg_q <= weighted[40];
    end else if ((ctrl.mdiv_step || ctrl.fdiv_step) && steps != '0) begin
      if (!rem_try[DIV_W]) begin
        rem <= rem_try;
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_W-1:0], dvd[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
      dvd   <= {dvd[DIV_W-2:0], 1'b0};
      steps <= steps - 1'b1;
    end
  end

  assign mem_val = zero_m ? 16'd0 : (one_m ? frc_pkg::Q15_ONE : quo[15:0]);
  assign prod    = $signed({1'b0, mem_val}) * out_mem[idx];
  // sample to peak distance fits in 16 magnitude bits
  assign diff    = 18'(s17) - 18'(p17);
  assign adiff   = diff[17] ? 17'(-diff) : 17'(diff);

  always_ff @(posedge clk) begin
    if (ctrl.clr_acc) begin
      weighted <= '0;
      total    <= '0;
      found    <= 1'b0;
      best     <= '0;
      near_out <= '0;
    end else if (ctrl.acc) begin
      weighted <= weighted + 41'(prod);
      total    <= total + DEN_W'(mem_val);
      if (!found || adiff < best) begin
        found    <= 1'b1;
        best     <= adiff;
        near_out <= out_mem[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.set_out) begin
      drive      <= '0;
      strength   <= '0;
      rule_index <= '0;
      status     <= 1'b0;
      last       <= 1'b1;
      case (ctrl.out_kind)
        frc_pkg::OUT_APPEND: status <= stat.full;
        frc_pkg::OUT_EVAL: begin
          if (total == '0) begin
            drive <= near_out;
          end else begin
            drive <= neg_q ? 16'(-quo[15:0]) : quo[15:0];
          end
        end
        frc_pkg::OUT_LIST: begin
          strength   <= mem_val;
          rule_index <= 3'(idx);
          last       <= stat.last_rule;
        end
        default: last <= 1'b1;
      endcase
    end
  end

  assign stat.cmd        = frc_pkg::cmd_t'(cmd);
  assign stat.full       = (rule_count >= frc_pkg::CNT_W'(frc_pkg::MAX_RULES));
  assign stat.empty      = (rule_count == '0);
  assign stat.last_rule  = (frc_pkg::CNT_W'(idx) + 1'b1 == rule_count);
  assign stat.div_done   = (steps == '0);
  assign stat.total_zero = (total == '0);

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    rule_count <= frc_pkg::CNT_W'(frc_pkg::MAX_RULES))
    else $error("rule count beyond table");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (ctrl.write_rule && stat.full) |=> $stable(rule_count))
    else $error("full table changed");
  a_mem_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.acc |-> (mem_val <= frc_pkg::Q15_ONE))
    else $error("membership above one");

endmodule

>>> rtl/fuzzy_rule_controller.sv
// ----------------------------------------------------------------------------
// fuzzy_rule_controller
// Zero-order Sugeno controller with triangular sets, up to MAX_RULES rules.
// ----------------------------------------------------------------------------
// Use: items arrive on in_ch (cmd, sample, rule fields); result beats leave
// on out_ch. cmd 0 appends a rule, one beat with status (1 = table full).
// cmd 1 evaluates the sample, one beat with drive. cmd 2 emits one beat per
// rule with strength and rule_index, last on the final one. cmd 3 and
// cmd 2 on an empty table give no beat.
// Flow: one item at a time. Append loads the output register in ST_APPEND
// and offers its beat from ST_OUT. Each rule runs its membership division
// on the shared one-bit-per-cycle 50-bit divider; evaluate adds one more
// division for the final result.
// Reset (rst, synchronous) empties the rule table; no clearing pass.
// A stalled receiver holds the beat in the output register and the block
// accepts no new item until the beat is taken.
// ----------------------------------------------------------------------------
module fuzzy_rule_controller (
  input logic       clk,
  input logic       rst,
  frc_in_if.sink    in_ch,
  frc_out_if.source out_ch
);

  frc_pkg::ctrl_t ctrl;
  frc_pkg::stat_t stat;

  frc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  frc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_cmd     (in_ch.cmd),
    .in_sample  (in_ch.sample),
    .in_left    (in_ch.rule_left),
    .in_peak    (in_ch.rule_peak),
    .in_right   (in_ch.rule_right),
    .in_output  (in_ch.rule_output),
    .drive      (out_ch.drive),
    .strength   (out_ch.strength),
    .rule_index (out_ch.rule_index),
    .status     (out_ch.status),
    .last       (out_ch.last)
  );

endmodule

>>> tb/sv/tb_fuzzy_rule_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fuzzy_rule_controller
// Self-checking bench: random and directed rule appends, evaluations and
// strength listings, with each result beat compared against an in-bench
// fixed-point model of the rule table, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_fuzzy_rule_controller;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] sample;
    logic signed [15:0] left;
    logic signed [15:0] peak;
    logic signed [15:0] right;
    logic signed [15:0] outv;
  } item_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic [15:0]        strength;
    logic [2:0]         rule_index;
    logic               status;
    logic               last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  frc_in_if  in_ch ();
  frc_out_if out_ch ();

  fuzzy_rule_controller dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  item_t pending_items[$];
  beat_t expected_beats[$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  // rule table copy
  int unsigned n_rules;
  int tbl_left[frc_pkg::MAX_RULES], tbl_peak[frc_pkg::MAX_RULES];
  int tbl_right[frc_pkg::MAX_RULES], tbl_out[frc_pkg::MAX_RULES];

  function automatic void queue_item(item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic void expect_beat(beat_t b);
    expected_beats = {expected_beats, b};
  endfunction

  function automatic longint membership(int s, int i);
    if (s <= tbl_left[i] || s >= tbl_right[i]) return 0;
    if (s == tbl_peak[i]) return 32768;
    if (s < tbl_peak[i]) return (longint'(s - tbl_left[i]) * 32768) / (tbl_peak[i] - tbl_left[i]);
    return (longint'(tbl_right[i] - s) * 32768) / (tbl_right[i] - tbl_peak[i]);
  endfunction

  task automatic predict_results(item_t it);
    beat_t  b;
    longint wsum, msum, m;
    int     s, d, best, drv;
    bit     found;
    s = it.sample;
    b = '0;
    b.last = 1'b1;
    case (frc_pkg::cmd_t'(it.cmd))
      frc_pkg::CMD_APPEND: begin
        if (n_rules >= frc_pkg::MAX_RULES) b.status = 1'b1;
        else begin
          tbl_left[n_rules] = it.left;
          tbl_peak[n_rules] = it.peak;
          tbl_right[n_rules] = it.right;
          tbl_out[n_rules] = it.outv;
          n_rules++;
        end
        expect_beat(b);
      end
      frc_pkg::CMD_EVAL: begin
        wsum = 0; msum = 0; drv = 0; found = 0; best = 0;
        for (int i = 0; i < n_rules; i++) begin
          m = membership(s, i);
          wsum += m * tbl_out[i];
          msum += m;
        end
        if (msum > 0) drv = int'(wsum / msum);
        else begin
          for (int i = 0; i < n_rules; i++) begin
            d = s - tbl_peak[i];
            if (d < 0) d = -d;
            if (!found || d < best) begin
              found = 1; best = d; drv = tbl_out[i];
            end
          end
        end
        b.drive = drv[15:0];
        expect_beat(b);
      end
      frc_pkg::CMD_LIST: begin
        for (int i = 0; i < n_rules; i++) begin
          b = '0;
          b.strength = 16'(membership(s, i));
          b.rule_index = 3'(i);
          b.last = (i + 1 == n_rules);
          expect_beat(b);
        end
      end
      default: ;
    endcase
  endtask

  // driver
  initial begin
    in_ch.valid = 1'b0;
    {in_ch.cmd, in_ch.sample, in_ch.rule_left, in_ch.rule_peak, in_ch.rule_right,
     in_ch.rule_output} = '0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) predict_results(pending_items.pop_front());
      if ((!in_ch.valid || in_ch.ready) ) begin
        if (pending_items.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid       <= 1'b1;
          in_ch.cmd         <= pending_items[0].cmd;
          in_ch.sample      <= pending_items[0].sample;
          in_ch.rule_left   <= pending_items[0].left;
          in_ch.rule_peak   <= pending_items[0].peak;
          in_ch.rule_right  <= pending_items[0].right;
          in_ch.rule_output <= pending_items[0].outv;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    beat_t got, exp_b;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.drive, out_ch.strength, out_ch.rule_index, out_ch.status, out_ch.last};
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat %h", $time, got);
        end else begin
          exp_b = expected_beats.pop_front();
          if (got.drive !== exp_b.drive) begin
            errors++;
            $display("%0t: drive exp %0d got %0d", $time, exp_b.drive, got.drive);
          end
          if (got.strength !== exp_b.strength) begin
            errors++;
            $display("%0t: strength exp %0d got %0d", $time, exp_b.strength, got.strength);
          end
          if (got.rule_index !== exp_b.rule_index) begin
            errors++;
            $display("%0t: rule_index exp %0d got %0d", $time, exp_b.rule_index,
                     got.rule_index);
          end
          if (got.status !== exp_b.status) begin
            errors++;
            $display("%0t: status exp %0b got %0b", $time, exp_b.status, got.status);
          end
          if (got.last !== exp_b.last) begin
            errors++;
            $display("%0t: last exp %0b got %0b", $time, exp_b.last, got.last);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic item_t make_item(logic [1:0] c, int s, int l, int p, int r, int o);
    item_t it;
    it.cmd = c; it.sample = 16'(s); it.left = 16'(l); it.peak = 16'(p);
    it.right = 16'(r); it.outv = 16'(o);
    return it;
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // sorted-ish triangle near a center, with some degenerate ones
  function automatic item_t rand_rule();
    int c, w1, w2;
    if ($urandom_range(9) == 0)
      return make_item(frc_pkg::CMD_APPEND, 0, $signed(rnd16()), $signed(rnd16()),
                       $signed(rnd16()), $signed(rnd16()));
    c  = $urandom_range(0, 4000) - 2000;
    w1 = $urandom_range(1, 1500);
    w2 = $urandom_range(1, 1500);
    return make_item(frc_pkg::CMD_APPEND, $signed(rnd16()), c - w1, c, c + w2,
                     $signed(rnd16()));
  endfunction

  function automatic item_t rand_query(logic [1:0] c);
    int s;
    s = ($urandom_range(3) == 0) ? $signed(rnd16()) : $urandom_range(0, 7000) - 3500;
    return make_item(c, s, $signed(rnd16()), $signed(rnd16()), $signed(rnd16()),
                     $signed(rnd16()));
  endfunction

  task automatic drain();
    while (pending_items.size() != 0 || expected_beats.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    int nr, sent;
    int idle_mix[4] = '{0, 85, 0, 9};
    int stall_mix[4] = '{0, 0, 85, 9};
    n_rules = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, full table, unused command
    queue_item(make_item(frc_pkg::CMD_EVAL, 100, 0, 0, 0, 0));
    queue_item(make_item(frc_pkg::CMD_LIST, 100, 0, 0, 0, 0));
    queue_item(make_item(frc_pkg::CMD_NONE, -1, -1, -1, -1, -1));
    queue_item(make_item(frc_pkg::CMD_APPEND, 0, -32768, 0, 32767, 32767));
    queue_item(make_item(frc_pkg::CMD_APPEND, -1, -256, 256, 512, -32768));
    queue_item(make_item(frc_pkg::CMD_APPEND, 0, 100, 50, 0, 1234));     // degenerate
    queue_item(make_item(frc_pkg::CMD_APPEND, 0, -32768, -32768, -32768, 7));
    queue_item(make_item(frc_pkg::CMD_EVAL, 0, 0, 0, 0, 0));             // at a peak
    queue_item(make_item(frc_pkg::CMD_EVAL, 32767, 0, 0, 0, 0));         // right foot
    queue_item(make_item(frc_pkg::CMD_EVAL, -32768, 0, 0, 0, 0));        // all zero
    queue_item(make_item(frc_pkg::CMD_LIST, 300, 0, 0, 0, 0));
    queue_item(make_item(frc_pkg::CMD_LIST, -32768, 0, 0, 0, 0));
    queue_item(make_item(frc_pkg::CMD_APPEND, 0, 1000, 2000, 3000, -500));
    queue_item(make_item(frc_pkg::CMD_APPEND, 0, 4000, 5000, 6000, 500)); // equal distance
    queue_item(make_item(frc_pkg::CMD_EVAL, 3500, 0, 0, 0, 0));          // tie of peaks, but rule 0 covers it
    queue_item(make_item(frc_pkg::CMD_APPEND, 0, 1, 2, 3, 4));
    queue_item(make_item(frc_pkg::CMD_APPEND, 0, 10, 20, 30, 40));
    queue_item(make_item(frc_pkg::CMD_APPEND, 0, 11, 21, 31, 41));       // table already full, dropped
    queue_item(make_item(frc_pkg::CMD_APPEND, 0, 5, 6, 7, 8));           // dropped
    queue_item(make_item(frc_pkg::CMD_LIST, 20, 0, 0, 0, 0));
    queue_item(make_item(frc_pkg::CMD_EVAL, 25, 0, 0, 0, 0));
    drain();

    // random phases; reset is not repeated, so table stays full after it fills
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_mix[ph];
      recv_stall_pct = stall_mix[ph];
      for (int k = 0; k < 110; k++) begin
        nr = $urandom_range(99);
        if (n_rules + pending_items.size() < 12 && nr < 30)
          queue_item(rand_rule());
        else if (nr < 40)
          queue_item(rand_rule());
        else if (nr < 70)
          queue_item(rand_query(frc_pkg::CMD_EVAL));
        else if (nr < 97)
          queue_item(rand_query(frc_pkg::CMD_LIST));
        else
          queue_item(rand_query(frc_pkg::CMD_NONE));
        sent++;
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    if (errors == 0 && expected_beats.size() == 0) begin
      $display("fuzzy_rule_controller test passed");
    end else begin
      $display("fuzzy_rule_controller test failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("fuzzy_rule_controller test failed");
    $finish;
  end

endmodule
